>>> rtl/tc_pkg.sv
// tc_pkg: widths, payload types and stage counts for the tetrahedron circumcenter
// no dependencies; used by every module of the block
package tc_pkg;

  // coordinate format, signed two's complement
  localparam int COORD_W = 32;
  // edge vectors, squares and cross terms
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int NORM_W  = PROD_W + 2;
  localparam int CROSS_W = PROD_W + 1;
  // wide multiplier built from chunk products
  localparam int CHUNK_W = 23;
  localparam int CHUNKS  = 3;
  localparam int MUL_W   = CHUNK_W * CHUNKS;
  localparam int MUL_P_W = 2 * MUL_W;
  localparam int SUM_W   = MUL_P_W + 2;
  // quotient bits kept before the saturation check
  localparam int QUO_W   = COORD_W + 2;
  localparam int RES_W   = QUO_W + 2;

  // stage counts
  localparam int FRONT_LAT = 3;
  localparam int MUL_LAT   = 4;
  localparam int LANE_LAT  = QUO_W + 5;
  localparam int TOTAL_LAT = FRONT_LAT + MUL_LAT + 1 + LANE_LAT;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [NORM_W-1:0]  norm_t;
  typedef logic signed [CROSS_W-1:0] cross_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    coord_t v0_x;
    coord_t v0_y;
    coord_t v0_z;
    coord_t v1_x;
    coord_t v1_y;
    coord_t v1_z;
    coord_t v2_x;
    coord_t v2_y;
    coord_t v2_z;
    coord_t v3_x;
    coord_t v3_y;
    coord_t v3_z;
  } tet_t;

  typedef struct packed {
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    logic   degenerate;
    logic   saturated;
  } center_t;

  // edge vectors, squared norms and cross products after the front stages
  typedef struct packed {
    edge_t  [2:0][2:0] e;
    norm_t  [2:0]      r;
    cross_t [2:0][2:0] c;
    coord_t [2:0]      v0;
  } front_t;

endpackage

>>> rtl/tc_mul.sv
// tc_mul: pipelined signed multiplier, MUL_W x MUL_W, four register stages
// depends on tc_pkg
module tc_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tc_pkg::MUL_W-1:0]     a,
  input  logic signed [tc_pkg::MUL_W-1:0]     b,
  output logic signed [tc_pkg::MUL_P_W-1:0]   p
);
  import tc_pkg::*;

  localparam int PP_W   = 2 * (CHUNK_W + 1);
  localparam int GRP_W  = PP_W + 2;
  localparam int GROUPS = 2 * CHUNKS - 1;

  logic signed [CHUNK_W:0]     ac [CHUNKS];
  logic signed [CHUNK_W:0]     bc [CHUNKS];
  logic signed [PP_W-1:0]      pp [CHUNKS][CHUNKS];
  logic signed [GRP_W-1:0]     grp_next [GROUPS];
  logic signed [GRP_W-1:0]     grp [GROUPS];
  logic signed [MUL_P_W-1:0]   lo_sum;
  logic signed [MUL_P_W-1:0]   mid_sum;
  logic signed [MUL_P_W-1:0]   top_term;

  // split operands: low chunks unsigned, top chunk carries the sign
  always_comb begin
    for (int i = 0; i < CHUNKS; i++) begin
      if (i == CHUNKS - 1) begin
        ac[i] = {a[MUL_W-1], a[i*CHUNK_W +: CHUNK_W]};
        bc[i] = {b[MUL_W-1], b[i*CHUNK_W +: CHUNK_W]};
      end else begin
        ac[i] = {1'b0, a[i*CHUNK_W +: CHUNK_W]};
        bc[i] = {1'b0, b[i*CHUNK_W +: CHUNK_W]};
      end
    end
  end

  // chunk products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CHUNKS; i++) begin
        for (int j = 0; j < CHUNKS; j++) begin
          pp[i][j] <= ac[i] * bc[j];
        end
      end
    end
  end

  // gather products of equal weight
  always_comb begin
    for (int s = 0; s < GROUPS; s++) begin
      grp_next[s] = '0;
    end
    for (int i = 0; i < CHUNKS; i++) begin
      for (int j = 0; j < CHUNKS; j++) begin
        grp_next[i+j] = grp_next[i+j] + GRP_W'(pp[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < GROUPS; s++) begin
        grp[s] <= grp_next[s];
      end
    end
  end

  // pairwise merge of weight groups
  always_ff @(posedge clk) begin
    if (en) begin
      lo_sum   <= MUL_P_W'(grp[0]) + (MUL_P_W'(grp[1]) <<< CHUNK_W);
      mid_sum  <= MUL_P_W'(grp[2]) + (MUL_P_W'(grp[3]) <<< CHUNK_W);
      top_term <= MUL_P_W'(grp[4]);
    end
  end

  // final sum
  always_ff @(posedge clk) begin
    if (en) begin
      p <= lo_sum + (mid_sum <<< (2 * CHUNK_W)) + (top_term <<< (4 * CHUNK_W));
    end
  end

endmodule

>>> rtl/tc_front.sv
// tc_front: edge vectors, squared norms and cross products, three register stages
// depends on tc_pkg
module tc_front (
  input  logic          clk,
  input  logic          en,
  input  tc_pkg::tet_t  item,
  output tc_pkg::front_t f
);
  import tc_pkg::*;

  coord_t vtx [4][3];
  edge_t  e1 [3][3];
  edge_t  e2 [3][3];
  coord_t v0_1 [3];
  coord_t v0_2 [3];
  prod_t  sq [3][3];
  prod_t  xa [3][3];
  prod_t  xb [3][3];

  assign vtx[0][0] = item.v0_x;
  assign vtx[0][1] = item.v0_y;
  assign vtx[0][2] = item.v0_z;
  assign vtx[1][0] = item.v1_x;
  assign vtx[1][1] = item.v1_y;
  assign vtx[1][2] = item.v1_z;
  assign vtx[2][0] = item.v2_x;
  assign vtx[2][1] = item.v2_y;
  assign vtx[2][2] = item.v2_z;
  assign vtx[3][0] = item.v3_x;
  assign vtx[3][1] = item.v3_y;
  assign vtx[3][2] = item.v3_z;

  // edges from vertex 0
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v0_1[i] <= vtx[0][i];
        for (int k = 0; k < 3; k++) begin
          e1[i][k] <= EDGE_W'(vtx[i+1][k]) - EDGE_W'(vtx[0][k]);
        end
      end
    end
  end

  // squares and cross-product terms; c_i = e_(i+1) x e_(i+2)
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        v0_2[i] <= v0_1[i];
        for (int k = 0; k < 3; k++) begin
          e2[i][k] <= e1[i][k];
          sq[i][k] <= e1[i][k] * e1[i][k];
          xa[i][k] <= e1[(i+1)%3][(k+1)%3] * e1[(i+2)%3][(k+2)%3];
          xb[i][k] <= e1[(i+1)%3][(k+2)%3] * e1[(i+2)%3][(k+1)%3];
        end
      end
    end
  end

  // norms and cross products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f.v0[i] <= v0_2[i];
        f.r[i]  <= NORM_W'(sq[i][0]) + NORM_W'(sq[i][1]) + NORM_W'(sq[i][2]);
        for (int k = 0; k < 3; k++) begin
          f.e[i][k] <= e2[i][k];
          f.c[i][k] <= CROSS_W'(xa[i][k]) - CROSS_W'(xb[i][k]);
        end
      end
    end
  end

endmodule

>>> rtl/tc_lane.sv
// tc_lane: one coordinate's divide, floor rounding, offset and clamp
// depends on tc_pkg; fed by the determinant and one numerator sum
module tc_lane (
  input  logic            clk,
  input  logic            en,
  input  tc_pkg::sum_t    num,
  input  tc_pkg::sum_t    det,
  input  tc_pkg::coord_t  v0,
  output tc_pkg::coord_t  center,
  output logic            sat,
  output logic            degen
);
  import tc_pkg::*;

  localparam logic signed [RES_W-1:0] RES_HI =
    {{(RES_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_LO = ~RES_HI;
  localparam coord_t C_HI = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t C_LO = {1'b1, {(COORD_W-1){1'b0}}};

  // sign normalization
  sum_t   dn;
  sum_t   nn;
  logic   zero_a;
  coord_t v0_a;
  // magnitude
  logic [SUM_W-1:0] mag_b;
  logic [SUM_W-1:0] dv_b;
  logic             neg_b;
  logic             zero_b;
  coord_t           v0_b;
  // divide chain, index 0 holds the overflow stage
  logic [SUM_W-1:0] rem  [QUO_W+1];
  logic [SUM_W-1:0] dv   [QUO_W];
  logic [QUO_W-1:0] quo  [QUO_W+1];
  logic             neg  [QUO_W+1];
  logic             zero [QUO_W+1];
  logic             ovf  [QUO_W+1];
  coord_t           v0c  [QUO_W+1];
  logic [SUM_W-1:0] shifted [QUO_W];
  logic             take [QUO_W];
  // rounding
  logic signed [RES_W-1:0] qs;
  logic signed [RES_W-1:0] qs_next;
  logic                    neg_d;
  logic                    zero_d;
  logic                    ovf_d;
  coord_t                  v0_d;
  logic signed [RES_W-1:0] res;

  always_ff @(posedge clk) begin
    if (en) begin
      dn     <= det[SUM_W-1] ? -det : det;
      nn     <= det[SUM_W-1] ? -num : num;
      zero_a <= (det == '0);
      v0_a   <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_b  <= nn[SUM_W-1];
      mag_b  <= nn[SUM_W-1] ? -nn : nn;
      dv_b   <= {dn[SUM_W-2:0], 1'b0};
      zero_b <= zero_a;
      v0_b   <= v0_a;
    end
  end

  // quotient too large for the kept bits: certain to clip
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= mag_b;
      dv[0]   <= dv_b;
      quo[0]  <= '0;
      neg[0]  <= neg_b;
      zero[0] <= zero_b;
      ovf[0]  <= (mag_b >= (dv_b << QUO_W));
      v0c[0]  <= v0_b;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  always_comb begin
    for (int j = 0; j < QUO_W; j++) begin
      shifted[j] = dv[j] << (QUO_W - 1 - j);
      take[j]    = (rem[j] >= shifted[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QUO_W; j++) begin
        rem[j+1]  <= take[j] ? rem[j] - shifted[j] : rem[j];
        quo[j+1]  <= {quo[j][QUO_W-2:0], take[j]};
        neg[j+1]  <= neg[j];
        zero[j+1] <= zero[j];
        ovf[j+1]  <= ovf[j];
        v0c[j+1]  <= v0c[j];
      end
      // divisor is only needed up to the last divide stage
      for (int j = 0; j < QUO_W - 1; j++) begin
        dv[j+1] <= dv[j];
      end
    end
  end

  // floor rounding for negative quotients
  always_comb begin
    if (neg[QUO_W]) begin
      qs_next = -$signed(RES_W'(quo[QUO_W]))
                - $signed(RES_W'(rem[QUO_W] != '0));
    end else begin
      qs_next = $signed(RES_W'(quo[QUO_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qs     <= qs_next;
      neg_d  <= neg[QUO_W];
      zero_d <= zero[QUO_W];
      ovf_d  <= ovf[QUO_W];
      v0_d   <= v0c[QUO_W];
    end
  end

  assign res = RES_W'(v0_d) + qs;

  // offset by vertex 0 and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      degen <= zero_d;
      if (zero_d) begin
        center <= '0;
        sat    <= 1'b0;
      end else if (ovf_d) begin
        center <= neg_d ? C_LO : C_HI;
        sat    <= 1'b1;
      end else if (res > RES_HI) begin
        center <= C_HI;
        sat    <= 1'b1;
      end else if (res < RES_LO) begin
        center <= C_LO;
        sat    <= 1'b1;
      end else begin
        center <= res[COORD_W-1:0];
        sat    <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/tetrahedron_circumcenter.sv
// tetrahedron_circumcenter: circumcenter of four vertices by Cramer's rule
// throughput one item per cycle; the whole pipeline holds when the output stalls
// the pipe depth is set by the 34 one-bit divide stages in each coordinate lane
// reset clears only the valid bits; data registers are not reset
module tetrahedron_circumcenter (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  tc_pkg::tet_t     item,
  output logic             result_valid,
  input  logic             result_ready,
  output tc_pkg::center_t  result
);
  import tc_pkg::*;

  logic [TOTAL_LAT-1:0] vld;
  logic                 adv;
  front_t               f;
  logic signed [MUL_P_W-1:0] det_p [3];
  logic signed [MUL_P_W-1:0] num_p [3][3];
  coord_t v0_pipe [MUL_LAT][3];
  coord_t v0_s    [3];
  sum_t   det_s;
  sum_t   num_s   [3];
  coord_t ctr     [3];
  logic   lane_sat [3];
  logic   lane_degen [3];

  // global advance: the pipe moves unless the result item is held
  assign adv          = !vld[TOTAL_LAT-1] || result_ready;
  assign item_ready   = adv;
  assign result_valid = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOTAL_LAT-2:0], item_valid};
    end
  end

  tc_front u_front (
    .clk  (clk),
    .en   (adv),
    .item (item),
    .f    (f)
  );

  // determinant terms and numerator terms
  for (genvar k = 0; k < 3; k++) begin : g_mul
    tc_mul u_det (
      .clk (clk),
      .en  (adv),
      .a   (MUL_W'(f.e[0][k])),
      .b   (MUL_W'(f.c[0][k])),
      .p   (det_p[k])
    );
    for (genvar i = 0; i < 3; i++) begin : g_num
      tc_mul u_num (
        .clk (clk),
        .en  (adv),
        .a   (MUL_W'(f.r[i])),
        .b   (MUL_W'(f.c[i][k])),
        .p   (num_p[k][i])
      );
    end
  end

  // vertex 0 follows the multipliers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        v0_pipe[0][k] <= f.v0[k];
        for (int s = 1; s < MUL_LAT; s++) begin
          v0_pipe[s][k] <= v0_pipe[s-1][k];
        end
      end
    end
  end

  // dot-product sums
  always_ff @(posedge clk) begin
    if (adv) begin
      det_s <= SUM_W'(det_p[0]) + SUM_W'(det_p[1]) + SUM_W'(det_p[2]);
      for (int k = 0; k < 3; k++) begin
        num_s[k] <= SUM_W'(num_p[k][0]) + SUM_W'(num_p[k][1]) + SUM_W'(num_p[k][2]);
        v0_s[k]  <= v0_pipe[MUL_LAT-1][k];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    tc_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .num    (num_s[k]),
      .det    (det_s),
      .v0     (v0_s[k]),
      .center (ctr[k]),
      .sat    (lane_sat[k]),
      .degen  (lane_degen[k])
    );
  end

  // result item
  always_comb begin
    result.center_x   = ctr[0];
    result.center_y   = ctr[1];
    result.center_z   = ctr[2];
    result.degenerate = lane_degen[0];
    result.saturated  = lane_sat[0] | lane_sat[1] | lane_sat[2];
  end

endmodule

>>> verif/testbench.sv
// testbench for tetrahedron_circumcenter: directed and random tetrahedra checked against
// an exact wide-integer Cramer's rule predictor; depends on rtl/tc_pkg.sv and the block rtl
`timescale 1ns / 100ps

module testbench;
  import tc_pkg::*;

  typedef logic signed [255:0] wide_t;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  tet_t    item;
  logic    result_valid;
  logic    result_ready;
  center_t result;

  center_t expected_centers[$];
  int      errors;
  logic    item_taken;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_len;

  tetrahedron_circumcenter u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // exact circumcenter: cramer's rule with floor division and clamping
  function automatic center_t circumcenter_of(tet_t t);
    wide_t   v[4][3];
    wide_t   e[3][3];
    wide_t   cr[3][3];
    wide_t   nrm[3];
    wide_t   det;
    wide_t   den;
    wide_t   num;
    wide_t   quo;
    wide_t   res;
    wide_t   hi_lim;
    wide_t   lo_lim;
    center_t o;
    logic [31:0] coords[3];
    logic    clipped;
    v[0][0] = wide_t'(t.v0_x); v[0][1] = wide_t'(t.v0_y); v[0][2] = wide_t'(t.v0_z);
    v[1][0] = wide_t'(t.v1_x); v[1][1] = wide_t'(t.v1_y); v[1][2] = wide_t'(t.v1_z);
    v[2][0] = wide_t'(t.v2_x); v[2][1] = wide_t'(t.v2_y); v[2][2] = wide_t'(t.v2_z);
    v[3][0] = wide_t'(t.v3_x); v[3][1] = wide_t'(t.v3_y); v[3][2] = wide_t'(t.v3_z);
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) e[i][k] = v[i+1][k] - v[0][k];
      nrm[i] = e[i][0] * e[i][0] + e[i][1] * e[i][1] + e[i][2] * e[i][2];
    end
    // cross products of edge pairs, cyclic order
    for (int i = 0; i < 3; i++) begin
      int a;
      int b;
      a = (i + 1) % 3;
      b = (i + 2) % 3;
      cr[i][0] = e[a][1] * e[b][2] - e[a][2] * e[b][1];
      cr[i][1] = e[a][2] * e[b][0] - e[a][0] * e[b][2];
      cr[i][2] = e[a][0] * e[b][1] - e[a][1] * e[b][0];
    end
    det = e[0][0] * cr[0][0] + e[0][1] * cr[0][1] + e[0][2] * cr[0][2];
    o = '0;
    if (det == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    hi_lim = wide_t'(32'sh7fffffff);
    lo_lim = -hi_lim - 1;
    clipped = 1'b0;
    for (int k = 0; k < 3; k++) begin
      num = nrm[0] * cr[0][k] + nrm[1] * cr[1][k] + nrm[2] * cr[2][k];
      den = det + det;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      // round toward minus infinity
      if (num >= 0) quo = num / den;
      else quo = -((-num + den - 1) / den);
      res = v[0][k] + quo;
      if (res > hi_lim) begin
        res = hi_lim;
        clipped = 1'b1;
      end else if (res < lo_lim) begin
        res = lo_lim;
        clipped = 1'b1;
      end
      coords[k] = res[31:0];
    end
    o.center_x  = coords[0];
    o.center_y  = coords[1];
    o.center_z  = coords[2];
    o.saturated = clipped;
    return o;
  endfunction

  // accept tracking, expectation store and result checks
  always @(posedge clk) begin
    center_t want;
    item_taken <= item_valid && item_ready && !rst;
    if (!rst && item_valid && item_ready) begin
      expected_centers.insert(expected_centers.size(), circumcenter_of(item));
    end
    if (!rst && result_valid && result_ready) begin
      if (expected_centers.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        want = expected_centers.pop_front();
        if (result.center_x !== want.center_x) begin
          $error("center_x expected %h actual %h", want.center_x, result.center_x);
          errors++;
        end
        if (result.center_y !== want.center_y) begin
          $error("center_y expected %h actual %h", want.center_y, result.center_y);
          errors++;
        end
        if (result.center_z !== want.center_z) begin
          $error("center_z expected %h actual %h", want.center_z, result.center_z);
          errors++;
        end
        if (result.degenerate !== want.degenerate) begin
          $error("degenerate expected %b actual %b", want.degenerate, result.degenerate);
          errors++;
        end
        if (result.saturated !== want.saturated) begin
          $error("saturated expected %b actual %b", want.saturated, result.saturated);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off counted down here
  always @(negedge clk) begin
    if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one item and hold it until taken, then maybe go idle
  task automatic send_tet(tet_t t);
    item_valid <= 1'b1;
    item <= t;
    do @(negedge clk); while (!item_taken);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
      @(negedge clk);
    end
  endtask

  function automatic tet_t tet_of(logic signed [31:0] s[12]);
    tet_t t;
    t = {s[0], s[1], s[2], s[3], s[4], s[5], s[6], s[7], s[8], s[9], s[10], s[11]};
    return t;
  endfunction

  function automatic logic signed [31:0] rand_coord(int span_bits);
    logic signed [31:0] c;
    c = $urandom;
    if (span_bits < 32) c = c >>> (32 - span_bits);
    return c;
  endfunction

  // random tetrahedron: mostly moderate coordinates, some full range, some flat
  function automatic tet_t rand_tet();
    logic signed [31:0] s[12];
    int kind;
    int span;
    kind = $urandom_range(9);
    span = (kind < 2) ? 32 : $urandom_range(8, 26);
    for (int i = 0; i < 12; i++) s[i] = rand_coord(span);
    if (kind == 9) begin
      // coplanar: all vertices share one z
      s[5] = s[2]; s[8] = s[2]; s[11] = s[2];
    end else if (kind == 8) begin
      // coincident vertices
      for (int k = 0; k < 3; k++) s[9+k] = s[6+k];
    end
    return tet_of(s);
  endfunction

  task automatic wait_drained();
    while (expected_centers.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    logic signed [31:0] s[12];
    int one;
    one = 32'sh10000;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // all zero: degenerate
    s = '{default: 0};
    send_tet(tet_of(s));
    // unit corner tetrahedron and its mirror (negative determinant)
    s = '{0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one};
    send_tet(tet_of(s));
    s = '{0, 0, 0, 0, one, 0, one, 0, 0, 0, 0, one};
    send_tet(tet_of(s));
    s = '{-one, -one, -one, one, 0, 0, 0, 3 * one, 0, 0, 0, -5 * one};
    send_tet(tet_of(s));
    // extremes of the coordinate range
    s = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
          32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
          32'sh80000000, 32'sh7fffffff};
    send_tet(tet_of(s));
    s = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
          32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
          32'sh7fffffff, 32'sh80000000};
    send_tet(tet_of(s));
    s = '{default: 32'sh7fffffff};
    send_tet(tet_of(s));
    s = '{default: 32'sh80000000};
    send_tet(tet_of(s));
    // nearly flat large tetrahedra, center clipped high and low
    s = '{0, 0, 0, 32'sh40000000, 0, 0, 0, 32'sh40000000, 0, 32'sh20000000,
          32'sh20000000, 1};
    send_tet(tet_of(s));
    s = '{0, 0, 0, 32'shc0000000, 0, 0, 0, 32'shc0000000, 0, 32'she0000000,
          32'she0000000, -1};
    send_tet(tet_of(s));
    // collinear and coincident points
    s = '{0, 0, 0, one, one, one, 2 * one, 2 * one, 2 * one, 0, 5, 9};
    send_tet(tet_of(s));
    s = '{7, 8, 9, 7, 8, 9, 1, 2, 3, 4, 5, 6};
    send_tet(tet_of(s));
    // smallest nonflat tetrahedron, floor rounding of negative quotients
    s = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_tet(tet_of(s));
    s = '{0, 0, 0, -1, 0, 0, 0, -1, 0, 0, 0, -1};
    send_tet(tet_of(s));
    s = '{3, -5, 2, -4, 7, 1, 6, 2, -3, 1, 1, 9};
    send_tet(tet_of(s));
    item_valid <= 1'b0;
    wait_drained();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) send_tet(rand_tet());
    item_valid <= 1'b0;
    wait_drained();
  endtask

  // receiver holds off long enough that the pipeline fills and stalls its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_len = 300;
    for (int n = 0; n < 150; n++) send_tet(rand_tet());
    item_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    item_taken = 1'b0;
    errors = 0;
    hold_len = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(250, 76, 0);
    test_random(250, 0, 76);
    test_random(250, 11, 11);
    test_backpressure();
    repeat (TOTAL_LAT + 20) @(negedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // run time limit
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> tetrahedron_circumcenter.f
rtl/tc_pkg.sv
rtl/tc_mul.sv
rtl/tc_front.sv
rtl/tc_lane.sv
rtl/tetrahedron_circumcenter.sv
verif/testbench.sv
